### rtl/core/srtf_pkg.sv
// Package for the shortest-remaining-time-first scheduler core.
// Holds the command codes and the packed word types of both channels.
package srtf_pkg;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_ARRIVE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  job_id;
    logic [15:0] service_time;
  } in_word_t;

  typedef struct packed {
    logic        running_valid;
    logic [7:0]  running_id;
    logic [15:0] running_remaining;
    logic        done_valid;
    logic [7:0]  done_id;
    logic        dropped;
    logic [4:0]  ready_count;
  } out_word_t;

endpackage

### rtl/core/srtf_queue.sv
// Two-entry word queue between the front and the back of the scheduler.
// Depends on srtf_pkg for the input word type.
module srtf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  srtf_pkg::in_word_t push_word,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output srtf_pkg::in_word_t pop_word
);

  srtf_pkg::in_word_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

### rtl/core/srtf_engine.sv
// Back part of the scheduler: holds the running job and the ready table,
// and scans the table one entry per cycle to pick the least remaining time.
// Depends on srtf_pkg for word types and command codes.
module srtf_engine #(
  parameter int READY_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         tick_step,
  input  logic               empty,
  input  srtf_pkg::in_word_t item,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output srtf_pkg::out_word_t res_word
);

  localparam int IW = (READY_DEPTH > 2) ? $clog2(READY_DEPTH + 2) : 2;
  localparam int CW = $clog2(READY_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_TAKE  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;

  logic [7:0]           ids   [READY_DEPTH + 2];
  logic [TIME_BITS-1:0] times [READY_DEPTH + 2];
  logic [IW-1:0]        fill;
  logic                 run_valid;
  logic [7:0]           run_id;
  logic [TIME_BITS-1:0] run_time;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        best;
  logic [TIME_BITS-1:0] best_time;
  logic [7:0]           best_id;
  logic                 done;
  logic [7:0]           done_id;
  logic                 drop;
  logic [7:0]           rd_id;
  logic [TIME_BITS-1:0] rd_time;
  logic [TIME_BITS-1:0] stime;
  logic [TIME_BITS:0]   step_ext;

  assign stime    = TIME_BITS'(item.service_time);
  assign step_ext = (TIME_BITS + 1)'(tick_step);
  assign pop      = (state == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    rd_id   <= ids[idx];
    rd_time <= times[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      run_valid <= 1'b0;
      run_id    <= '0;
      run_time  <= '0;
      res_valid <= 1'b0;
      idx       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!empty) begin
            idx <= '0;
            if (item.cmd == srtf_pkg::CMD_TICK) begin
              drop <= 1'b0;
              if (run_valid && run_time == '0) begin
                done <= 1'b1;
                done_id <= run_id;
                if (fill != '0) begin
                  state <= S_TAKE;
                end else begin
                  run_valid <= 1'b0;
                  run_id <= '0;
                  state <= S_OUT;
                end
              end else begin
                done <= 1'b0;
                done_id <= '0;
                state <= S_OUT;
                if (run_valid) begin
                  if ({1'b0, run_time} > step_ext) begin
                    run_time <= run_time - TIME_BITS'(tick_step);
                  end else begin
                    run_time <= '0;
                  end
                end
              end
            end else begin
              done <= 1'b0;
              done_id <= '0;
              if (fill >= IW'(READY_DEPTH)) begin
                drop <= 1'b1;
                state <= S_OUT;
              end else begin
                drop <= 1'b0;
                ids[fill] <= item.job_id;
                times[fill] <= stime;
                if (run_valid && run_time != '0) begin
                  ids[fill + IW'(1)] <= run_id;
                  times[fill + IW'(1)] <= run_time;
                  fill <= fill + IW'(2);
                end else begin
                  fill <= fill + IW'(1);
                end
                state <= S_TAKE;
              end
            end
          end
        end
        S_TAKE: begin
          idx <= IW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (idx == IW'(1)) begin
            best <= '0;
            best_time <= rd_time;
            best_id <= rd_id;
          end else if (rd_time < best_time) begin
            best <= idx - IW'(1);
            best_time <= rd_time;
            best_id <= rd_id;
          end
          if (idx >= fill) begin
            state <= S_SHIFT;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_SHIFT: begin
          if (best + IW'(1) < fill) begin
            ids[best] <= ids[best + IW'(1)];
            times[best] <= times[best + IW'(1)];
            best <= best + IW'(1);
          end else begin
            run_valid <= 1'b1;
            run_id <= best_id;
            run_time <= best_time;
            fill <= fill - IW'(1);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res_word.running_valid <= run_valid;
            res_word.running_id <= run_valid ? run_id : 8'd0;
            res_word.running_remaining <= run_valid ? 16'(run_time) : 16'd0;
            res_word.done_valid <= done;
            res_word.done_id <= done_id;
            res_word.dropped <= drop;
            res_word.ready_count <= 5'(fill[CW-1:0]);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (res_valid && !res_stall && state != S_OUT) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/srtf_scheduler_core.sv
// Shortest-remaining-time-first scheduler top level; front queue plus engine.
// A plain tick or a dropped arrival goes from idle straight to the result register; an arrival
// or a completion with jobs waiting first passes the take, scan and shift states, where up to
// READY_DEPTH + 1 table entries are scanned and shifted one per cycle.
// One word is worked on at a time; the next is taken the cycle after a result is registered.
// Synchronous reset empties the table, clears the running job and sets tick_step to 1.
module srtf_scheduler_core #(
  parameter int READY_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  srtf_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output srtf_pkg::out_word_t out_word
);

  logic [7:0]         tick_step;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  srtf_pkg::in_word_t q_word;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      tick_step <= cfg_data;
    end
  end

  srtf_queue u_queue (
    .clk(clk), .rst(rst), .push(in_valid), .push_word(in_word), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_word(q_word)
  );

  srtf_engine #(.READY_DEPTH(READY_DEPTH), .TIME_BITS(TIME_BITS)) u_engine (
    .clk(clk), .rst(rst), .tick_step(tick_step), .empty(q_empty), .item(q_word),
    .pop(q_pop), .res_valid(out_valid), .res_stall(out_stall), .res_word(out_word)
  );

endmodule

### rtl/core/srtf_checker.sv
// Port-level checks for the scheduler core, bound to the top level.
// Depends on srtf_pkg for the word types.
module srtf_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input srtf_pkg::out_word_t out_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word)) else $error("result moved");
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.running_valid |-> out_word.running_id == 8'd0)
    else $error("idle id");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.ready_count <= 5'd16) else $error("count");
  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.dropped |-> !out_word.done_valid) else $error("drop and done");

endmodule

bind srtf_scheduler_core srtf_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);

### verif/srtf_scheduler_checker.sv
// Checker for the SRTF scheduler core: watches the word channels, predicts each
// result word from its own scheduler state and compares field by field.
// Depends on srtf_pkg for the word types and command codes.
module srtf_scheduler_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  srtf_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  srtf_pkg::out_word_t out_word,
  output int                  fail_count,
  output int                  pending,
  output int                  ticks_seen,
  output int                  arrivals_seen,
  output int                  dones_seen,
  output int                  drops_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  logic [7:0]  wait_ids[DEPTH+2];
  logic [15:0] wait_times[DEPTH+2];
  int          wait_fill;
  logic        job_valid;
  logic [7:0]  job_id;
  logic [15:0] job_time;
  logic [7:0]  step_size;
  srtf_pkg::out_word_t expected_words[$];

  assign pending = expected_words.size();

  function automatic void promote_shortest(input int n);
    int best;
    best = 0;
    for (int i = 1; i < n; i++)
      if (wait_times[i] < wait_times[best]) best = i;
    job_valid = 1'b1;
    job_id = wait_ids[best];
    job_time = wait_times[best];
    for (int i = best; i + 1 < n; i++) begin
      wait_ids[i] = wait_ids[i+1];
      wait_times[i] = wait_times[i+1];
    end
    wait_fill = n - 1;
  endfunction

  function automatic srtf_pkg::out_word_t schedule_word(input srtf_pkg::in_word_t w);
    srtf_pkg::out_word_t r;
    int n;
    r = '0;
    if (w.cmd == srtf_pkg::CMD_TICK) begin
      if (job_valid) begin
        if (job_time == 0) begin
          r.done_valid = 1'b1;
          r.done_id = job_id;
          if (wait_fill > 0) begin
            promote_shortest(wait_fill);
          end else begin
            job_valid = 1'b0;
            job_id = '0;
            job_time = '0;
          end
        end else if (job_time > step_size) begin
          job_time = job_time - step_size;
        end else begin
          job_time = '0;
        end
      end
    end else if (wait_fill >= DEPTH) begin
      r.dropped = 1'b1;
    end else begin
      n = wait_fill;
      wait_ids[n] = w.job_id;
      wait_times[n] = w.service_time;
      n++;
      if (job_valid && job_time > 0) begin
        wait_ids[n] = job_id;
        wait_times[n] = job_time;
        n++;
      end
      promote_shortest(n);
    end
    r.running_valid = job_valid;
    r.running_id = job_valid ? job_id : 8'd0;
    r.running_remaining = job_valid ? job_time : 16'd0;
    r.ready_count = 5'(wait_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    srtf_pkg::out_word_t e;
    if (rst) begin
      wait_fill = 0;
      job_valid = 1'b0;
      job_id = '0;
      job_time = '0;
      step_size = 8'd1;
      expected_words.delete();
      fail_count <= 0;
      ticks_seen <= 0;
      arrivals_seen <= 0;
      dones_seen <= 0;
      drops_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) step_size = cfg_data;
      if (in_valid && !in_stall) begin
        e = schedule_word(in_word);
        expected_words.insert(expected_words.size(), e);
        if (in_word.cmd == srtf_pkg::CMD_TICK) ticks_seen <= ticks_seen + 1;
        else arrivals_seen <= arrivals_seen + 1;
        if (e.done_valid) dones_seen <= dones_seen + 1;
        if (e.dropped) drops_seen <= drops_seen + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word %h", out_word);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (out_word !== e) begin
            fail_count <= fail_count + 1;
            if (out_word.running_valid !== e.running_valid)
              $error("running_valid: expected %0d, got %0d", e.running_valid,
                     out_word.running_valid);
            if (out_word.running_id !== e.running_id)
              $error("running_id: expected %0d, got %0d", e.running_id,
                     out_word.running_id);
            if (out_word.running_remaining !== e.running_remaining)
              $error("running_remaining: expected %0d, got %0d",
                     e.running_remaining, out_word.running_remaining);
            if (out_word.done_valid !== e.done_valid)
              $error("done_valid: expected %0d, got %0d", e.done_valid,
                     out_word.done_valid);
            if (out_word.done_id !== e.done_id)
              $error("done_id: expected %0d, got %0d", e.done_id, out_word.done_id);
            if (out_word.dropped !== e.dropped)
              $error("dropped: expected %0d, got %0d", e.dropped, out_word.dropped);
            if (out_word.ready_count !== e.ready_count)
              $error("ready_count: expected %0d, got %0d", e.ready_count,
                     out_word.ready_count);
          end
        end
      end
    end
  end

endmodule

### verif/tb_srtf_scheduler_core.sv
// Top of the SRTF scheduler core testbench: clock, reset, stimulus and verdict.
// Depends on srtf_pkg, srtf_scheduler_core and srtf_scheduler_checker.
module tb_srtf_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  srtf_pkg::in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  srtf_pkg::out_word_t out_word;
  int        fail_count, pending, n_tick, n_arrive, n_done, n_drop;
  int        quiet = 0;
  bit        calm = 1'b0;
  bit        hold_off = 1'b0;

  always #10 clk = ~clk;

  srtf_scheduler_core uut (.*);

  srtf_scheduler_checker checker_i (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word, .fail_count, .pending,
    .ticks_seen(n_tick), .arrivals_seen(n_arrive), .dones_seen(n_done),
    .drops_seen(n_drop)
  );

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= !calm && ($urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > LIMIT) begin
      $display("tb_srtf_scheduler_core: FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic c, input logic [7:0] id, input logic [15:0] t);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{cmd: c, job_id: id, service_time: t};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_step(input logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int count, input int arrive_pct, input int tmax);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < arrive_pct)
        send_word(srtf_pkg::CMD_ARRIVE, 8'($urandom), 16'($urandom_range(tmax)));
      else
        send_word(srtf_pkg::CMD_TICK, 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: idle tick, extremes, ties, zero-time arrival, fill and overflow.
    send_word(srtf_pkg::CMD_TICK, 8'hFF, 16'hFFFF);
    send_word(srtf_pkg::CMD_ARRIVE, 8'h00, 16'd0);
    send_word(srtf_pkg::CMD_ARRIVE, 8'hFF, 16'hFFFF);
    send_word(srtf_pkg::CMD_TICK, 8'h00, 16'h0000);
    send_word(srtf_pkg::CMD_TICK, 8'h00, 16'h0000);
    send_word(srtf_pkg::CMD_TICK, 8'h00, 16'h0000);
    for (int i = 0; i < 18; i++) send_word(srtf_pkg::CMD_ARRIVE, 8'(i + 1), 16'd5);
    drain();
    // Long receiver hold-off while arrivals keep coming, so the block backs up.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        random_phase(40, 50, 300);
        drain();
      end
    join
    drain();
    set_step(8'd0);
    random_phase(60, 40, 8);
    set_step(8'd255);
    random_phase(300, 30, 2000);
    set_step(8'd1);
    calm = 1'b1;
    random_phase(300, 35, 6);
    calm = 1'b0;
    set_step(8'($urandom_range(2, 254)));
    random_phase(400, 55, 65535);
    set_step(8'd3);
    random_phase(400, 40, 40);
    drain();
    $display("Covered %0d ticks, %0d arrivals, %0d completions, %0d drops,",
             n_tick, n_arrive, n_done, n_drop);
    $display("over tick steps 0, 1, 3, 255 and a random one, with hold-offs.");
    if (fail_count == 0) $display("tb_srtf_scheduler_core: PASS");
    else $display("tb_srtf_scheduler_core: FAIL");
    $finish;
  end

endmodule

### files.f
rtl/core/srtf_pkg.sv
rtl/core/srtf_queue.sv
rtl/core/srtf_engine.sv
rtl/core/srtf_scheduler_core.sv
rtl/core/srtf_checker.sv
verif/srtf_scheduler_checker.sv
verif/tb_srtf_scheduler_core.sv
